/* src/kest_pkg.sv */
// Package for the key edge state tracker.
// Holds key state codes, operation and action codes and the RAM control struct.
// No dependencies.
package kest_pkg;

  typedef logic [1:0] st_t;

  localparam st_t ST_NONE     = 2'd0;
  localparam st_t ST_PRESSED  = 2'd1;
  localparam st_t ST_HELD     = 2'd2;
  localparam st_t ST_RELEASED = 2'd3;

  typedef logic [2:0] op_t;

  localparam op_t OP_KEY_EVENT  = 3'd0;
  localparam op_t OP_FRAME_TICK = 3'd1;
  localparam op_t OP_QRY_REL    = 3'd2;
  localparam op_t OP_QRY_PRS    = 3'd3;
  localparam op_t OP_QRY_HLD    = 3'd4;

  typedef logic [1:0] act_t;

  localparam act_t ACT_RELEASE = 2'd0;
  localparam act_t ACT_PRESS   = 2'd1;

  // Write enables for the current-frame and next-frame tables
  typedef struct packed {
    logic cur_we;
    logic nxt_we;
  } mem_ctl_t;

  // Pressed and held advance to held; released and none fall to none
  function automatic st_t advance_state(input st_t s);
    advance_state = (s == ST_PRESSED || s == ST_HELD) ? ST_HELD : ST_NONE;
  endfunction

  // State that a query operation asks about
  function automatic st_t wanted_state(input op_t op);
    case (op)
      OP_QRY_REL: wanted_state = ST_RELEASED;
      OP_QRY_PRS: wanted_state = ST_PRESSED;
      default:    wanted_state = ST_HELD;
    endcase
  endfunction

endpackage

/* src/key_edge_state_tracker_unit.sv */
// Top level of the key edge state tracker.
// Depends on kest_pkg, kest_ram and kest_seq.
//
// Usage:
//   Command channel: present in_operation, in_key_index and in_action with
//   start high; the command transfers at a rising edge where busy is low.
//   Operations: key event (press, release; other actions are dropped), frame tick,
//   and queries for released, just pressed or held (key 0 means any key).
//   Result channel: each query answers with out_answer marked by a one-cycle
//   out_valid strobe; the receiver cannot hold results off, so take the
//   transfer in that cycle. Events and ticks give no result.
// Passes (N = KEY_COUNT):
//   Key event: the entry is read at the transfer edge, then busy is high
//   while the next table is written back; a new command waits for that.
//   Single-key query: the strobe is registered from the query state.
//   Frame tick: sweeps all N entries of both tables at one entry a cycle.
//   Any-key query: sweeps the current table, strobe after the last entry.
//   The single read and write port of each table sets this pacing.
// Reset: rst_n low clears control state; afterwards a clearing pass over all
//   N entries zeroes both tables while busy stays high.
module key_edge_state_tracker_unit #(
  parameter int KEY_COUNT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [10:0] in_key_index,
  input  logic [1:0]  in_action,
  output logic        out_valid,
  output logic        out_answer
);

  localparam int AW = KEY_COUNT > 1 ? $clog2(KEY_COUNT) : 1;

  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  kest_pkg::mem_ctl_t  mem_ctl;
  kest_pkg::st_t       cur_rd_data;
  kest_pkg::st_t       nxt_rd_data;
  kest_pkg::st_t       cur_wdata;
  kest_pkg::st_t       nxt_wdata;

  // Command decode and table passes
  kest_seq #(
    .KEY_COUNT (KEY_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_action    (in_action),
    .rd_addr      (rd_addr),
    .cur_rd_data  (cur_rd_data),
    .nxt_rd_data  (nxt_rd_data),
    .wr_addr      (wr_addr),
    .mem_ctl      (mem_ctl),
    .cur_wdata    (cur_wdata),
    .nxt_wdata    (nxt_wdata),
    .out_valid    (out_valid),
    .out_answer   (out_answer)
  );

  // Current-frame table: queries read it, frame ticks fill it
  kest_ram #(
    .WIDTH (2),
    .DEPTH (KEY_COUNT)
  ) u_cur_ram (
    .clk   (clk),
    .we    (mem_ctl.cur_we),
    .waddr (wr_addr),
    .wdata (cur_wdata),
    .raddr (rd_addr),
    .rdata (cur_rd_data)
  );

  // Next-frame table: key events update it, frame ticks advance it
  kest_ram #(
    .WIDTH (2),
    .DEPTH (KEY_COUNT)
  ) u_nxt_ram (
    .clk   (clk),
    .we    (mem_ctl.nxt_we),
    .waddr (wr_addr),
    .wdata (nxt_wdata),
    .raddr (rd_addr),
    .rdata (nxt_rd_data)
  );

endmodule

/* src/kest_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kest_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/kest_seq.sv */
// Sequencer of the key edge state tracker: decodes commands, runs the
// read-modify-write, sweep and clearing passes over both tables.
// Depends on kest_pkg.
module kest_seq #(
  parameter int KEY_COUNT = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  kest_pkg::op_t            in_operation,
  input  logic [10:0]              in_key_index,
  input  kest_pkg::act_t           in_action,
  output logic [(KEY_COUNT > 1 ? $clog2(KEY_COUNT) : 1)-1:0] rd_addr,
  input  kest_pkg::st_t            cur_rd_data,
  input  kest_pkg::st_t            nxt_rd_data,
  output logic [(KEY_COUNT > 1 ? $clog2(KEY_COUNT) : 1)-1:0] wr_addr,
  output kest_pkg::mem_ctl_t       mem_ctl,
  output kest_pkg::st_t            cur_wdata,
  output kest_pkg::st_t            nxt_wdata,
  output logic                     out_valid,
  output logic                     out_answer
);

  localparam int AW = KEY_COUNT > 1 ? $clog2(KEY_COUNT) : 1;
  localparam logic [AW-1:0] LAST = AW'(KEY_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVT   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_ANY   = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_answer_r, out_answer_nxt;
  logic [AW-1:0]   key_r, key_nxt;
  kest_pkg::act_t  act_r, act_nxt;
  kest_pkg::st_t   want_r, want_nxt;
  logic            inrange_r, inrange_nxt;
  logic            hit_r, hit_nxt;

  logic [AW-1:0]   key_addr;
  logic            key_inrange;
  logic            accept;

  assign key_addr    = AW'(in_key_index);
  assign key_inrange = 32'(in_key_index) < KEY_COUNT;
  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_answer_nxt = 1'b0;
    key_nxt        = key_r;
    act_nxt        = act_r;
    want_nxt       = want_r;
    inrange_nxt    = inrange_r;
    hit_nxt        = hit_r;
    rd_addr        = idx_r;
    wr_addr        = idx_r;
    mem_ctl        = '0;
    cur_wdata      = kest_pkg::ST_NONE;
    nxt_wdata      = kest_pkg::ST_NONE;

    unique case (state_r)
      S_CLEAR: begin
        // Zero both tables, one entry a cycle
        mem_ctl.cur_we = 1'b1;
        mem_ctl.nxt_we = 1'b1;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = (in_operation == kest_pkg::OP_FRAME_TICK) ? '0 : key_addr;
        idx_nxt = '0;
        if (accept) begin
          key_nxt     = key_addr;
          act_nxt     = in_action;
          inrange_nxt = key_inrange;
          want_nxt    = kest_pkg::wanted_state(in_operation);
          hit_nxt     = 1'b0;
          case (in_operation) inside
            kest_pkg::OP_KEY_EVENT: begin
              if (key_inrange && (in_action == kest_pkg::ACT_PRESS ||
                                  in_action == kest_pkg::ACT_RELEASE)) begin
                state_nxt = S_EVT;
              end
            end
            kest_pkg::OP_FRAME_TICK: begin
              state_nxt = S_TICK;
            end
            kest_pkg::OP_QRY_REL, kest_pkg::OP_QRY_PRS, kest_pkg::OP_QRY_HLD: begin
              state_nxt = (in_key_index == '0) ? S_ANY : S_QRY;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EVT: begin
        // Next-frame entry is on the read port now; modify and write back
        wr_addr        = key_r;
        mem_ctl.nxt_we = 1'b1;
        if (act_r == kest_pkg::ACT_RELEASE) begin
          nxt_wdata = kest_pkg::ST_RELEASED;
        end else if (nxt_rd_data == kest_pkg::ST_HELD) begin
          nxt_wdata = kest_pkg::ST_HELD;
        end else begin
          nxt_wdata = kest_pkg::ST_PRESSED;
        end
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        out_valid_nxt  = 1'b1;
        out_answer_nxt = inrange_r && (cur_rd_data == want_r);
        state_nxt      = S_IDLE;
      end
      S_TICK: begin
        // Write entry idx while reading idx + 1
        mem_ctl.cur_we = 1'b1;
        mem_ctl.nxt_we = 1'b1;
        cur_wdata      = nxt_rd_data;
        nxt_wdata      = kest_pkg::advance_state(nxt_rd_data);
        rd_addr        = idx_r + 1'b1;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_ANY: begin
        rd_addr = idx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        hit_nxt = hit_r || (cur_rd_data == want_r);
        if (idx_r == LAST) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = hit_nxt;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      out_answer_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_answer_r <= out_answer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    act_r     <= act_nxt;
    want_r    <= want_nxt;
    inrange_r <= inrange_nxt;
    hit_r     <= hit_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

`ifndef NO_ASSERTIONS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_QRY || $past(state_r) == S_ANY))
    else $error("answer strobe without a finished query");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_QRY || state_r == S_ANY)
      |-> !(mem_ctl.cur_we || mem_ctl.nxt_we))
    else $error("table write outside an update pass");

  a_evt_next_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVT |-> (mem_ctl.nxt_we && !mem_ctl.cur_we && wr_addr == key_r))
    else $error("key event touched the wrong entry or table");

  a_evt_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVT |=> state_r == S_IDLE)
    else $error("key event update did not finish in one cycle");
`endif

endmodule
